@@ rtl/icov_pkg.sv @@
// ----------------------------------------------------------------------------
// icov_pkg
// Shared types, constants and helpers for the interval coverage histogram.
// ----------------------------------------------------------------------------
package icov_pkg;

	localparam int POSITIONS = 65536;
	localparam int MAX_COVER = 100;
	localparam int ADDR_W    = $clog2(POSITIONS);
	localparam int POS_W     = ADDR_W + 1;
	localparam int BIN_W     = $clog2(MAX_COVER + 1);
	localparam int CNT_W     = 17;
	localparam int SUM_W     = 32;

	localparam logic [7:0]       MASKED  = 8'd255;
	localparam logic [7:0]       COV_MAX = 8'(MAX_COVER);
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [POS_W-1:0] POS_ALL = POS_W'(POSITIONS);

	// input op codes
	localparam logic [2:0] OP_BEGIN  = 3'd0;
	localparam logic [2:0] OP_ALLOW  = 3'd1;
	localparam logic [2:0] OP_GAP    = 3'd2;
	localparam logic [2:0] OP_ADD    = 3'd3;
	localparam logic [2:0] OP_FINISH = 3'd4;
	localparam logic [2:0] OP_READ   = 3'd5;

	// internal command kinds
	localparam logic [2:0] K_NOP    = 3'd0;
	localparam logic [2:0] K_BEGIN  = 3'd1;
	localparam logic [2:0] K_WRITE  = 3'd2;
	localparam logic [2:0] K_ADD    = 3'd3;
	localparam logic [2:0] K_FINISH = 3'd4;
	localparam logic [2:0] K_READ   = 3'd5;

	// config register indexes
	localparam logic CFG_LENGTH   = 1'b0;
	localparam logic CFG_RESTRICT = 1'b1;

	typedef struct packed {
		logic [2:0]       op;
		logic [POS_W-1:0] range_start;
		logic [POS_W-1:0] range_end;
		logic [6:0]       bin_index;
	} in_item_t;

	typedef struct packed {
		logic             status;
		logic [CNT_W-1:0] unrestricted_count;
		logic [SUM_W-1:0] depth_sum;
		logic [CNT_W-1:0] covered_count;
		logic [CNT_W-1:0] bin_count;
	} out_item_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic             status;
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] stop;
		logic [7:0]       fill;
		logic [6:0]       bin;
	} cmd_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
	endfunction

endpackage

@@ rtl/icov_front.sv @@
// ----------------------------------------------------------------------------
// icov_front
// Accepts requests, checks ranges and queues decoded commands (two deep).
// ----------------------------------------------------------------------------
module icov_front import icov_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_item,
	input  logic [POS_W-1:0] seq_length,
	input  logic             restrict_en,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output cmd_t             cmd
);

	cmd_t             q_mem [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;
	logic [POS_W-1:0] len;
	logic             bad;
	cmd_t             dec;
	logic             push, pop;

	assign len = (seq_length > POS_ALL) ? POS_ALL : seq_length;
	assign bad = (in_item.range_start > len) || (in_item.range_end > len);

	always_comb begin
		dec        = '0;
		dec.start  = in_item.range_start;
		dec.stop   = in_item.range_end;
		dec.bin    = in_item.bin_index;
		dec.kind   = K_NOP;
		case (in_item.op)
			OP_BEGIN: begin
				dec.kind  = K_BEGIN;
				dec.start = '0;
				dec.stop  = POS_ALL;
				dec.fill  = restrict_en ? MASKED : 8'd0;
			end
			OP_ALLOW, OP_GAP, OP_ADD: begin
				if (bad) begin
					dec.status = 1'b1;
				end else begin
					dec.kind = (in_item.op == OP_ADD) ? K_ADD : K_WRITE;
					dec.fill = (in_item.op == OP_GAP) ? MASKED : 8'd0;
				end
			end
			OP_FINISH: begin
				dec.kind  = K_FINISH;
				dec.start = '0;
				dec.stop  = len;
			end
			OP_READ: dec.kind = K_READ;
			default: dec.kind = K_NOP;
		endcase
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_mem[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_ptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ rtl/icov_back.sv @@
// ----------------------------------------------------------------------------
// icov_back
// Executes commands on the coverage store and histogram; holds the result.
// ----------------------------------------------------------------------------
module icov_back import icov_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_t      cmd,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_WR    = 4'd1;
	localparam logic [3:0] ST_ADD   = 4'd2;
	localparam logic [3:0] ST_HCLR  = 4'd3;
	localparam logic [3:0] ST_FRD   = 4'd4;
	localparam logic [3:0] ST_FHIST = 4'd5;
	localparam logic [3:0] ST_FUPD  = 4'd6;
	localparam logic [3:0] ST_BRD   = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;
	localparam logic [3:0] ST_INIT  = 4'd9;

	logic [7:0]       store_mem [POSITIONS];
	logic [CNT_W-1:0] hist_mem [MAX_COVER+1];

	logic [3:0]       state_q;
	cmd_t             cmd_q;
	logic [POS_W-1:0] pos_q, pos_nx;
	logic             rv_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [BIN_W-1:0] bin_q;
	logic [SUM_W-1:0] depth_q;
	logic [CNT_W-1:0] cov_q, unr_q, binc_q;
	logic             out_valid_q;
	out_item_t        out_q;
	logic [SUM_W:0]   depth_add;

	logic              st_we;
	logic [ADDR_W-1:0] st_wa, st_ra;
	logic [7:0]        st_wd, st_rd_q;
	logic              hs_we;
	logic [BIN_W-1:0]  hs_wa, hs_ra;
	logic [CNT_W-1:0]  hs_wd, hs_rd_q;

	assign pos_nx    = pos_q + POS_W'(1);
	assign cmd_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign depth_add = {1'b0, depth_q} + (SUM_W+1)'(cmd.stop - cmd.start);

	always_comb begin
		st_we = 1'b0;
		st_wa = pos_q[ADDR_W-1:0];
		st_wd = cmd_q.fill;
		st_ra = pos_q[ADDR_W-1:0];
		hs_we = 1'b0;
		hs_wa = pos_q[BIN_W-1:0];
		hs_wd = '0;
		hs_ra = bin_q;
		case (state_q)
			ST_IDLE: hs_ra = cmd.bin[BIN_W-1:0];
			ST_WR: begin
				st_we = 1'b1;
				hs_we = (cmd_q.kind == K_BEGIN) && (pos_q <= POS_W'(MAX_COVER));
			end
			ST_ADD: begin
				st_wa = addr_s1;
				st_wd = st_rd_q + 8'd1;
				st_we = rv_s1 && (st_rd_q < COV_MAX);
			end
			ST_HCLR: hs_we = 1'b1;
			ST_INIT: hs_we = 1'b1;
			ST_FHIST: hs_ra = st_rd_q[BIN_W-1:0];
			ST_FUPD: begin
				hs_we = 1'b1;
				hs_wa = bin_q;
				hs_wd = sat_inc(hs_rd_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) store_mem[st_wa] <= st_wd;
		st_rd_q <= store_mem[st_ra];
	end

	always_ff @(posedge clk) begin
		if (hs_we) hist_mem[hs_wa] <= hs_wd;
		hs_rd_q <= hist_mem[hs_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			pos_q       <= '0;
			rv_s1       <= 1'b0;
			depth_q     <= '0;
			cov_q       <= '0;
			unr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					// histogram clearing pass after reset
					if (pos_q == POS_W'(MAX_COVER)) begin
						pos_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						pos_q <= pos_nx;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q  <= cmd;
						pos_q  <= cmd.start;
						binc_q <= '0;
						rv_s1  <= 1'b0;
						state_q <= ST_DONE;
						case (cmd.kind)
							K_BEGIN: begin
								depth_q <= '0;
								cov_q   <= '0;
								unr_q   <= '0;
								state_q <= ST_WR;
							end
							K_WRITE: if (cmd.stop > cmd.start) state_q <= ST_WR;
							K_ADD: begin
								if (cmd.stop > cmd.start) begin
									depth_q <= depth_add[SUM_W] ? '1 : depth_add[SUM_W-1:0];
								end
								state_q <= ST_ADD;
							end
							K_FINISH: begin
								cov_q   <= '0;
								unr_q   <= '0;
								pos_q   <= '0;
								state_q <= ST_HCLR;
							end
							K_READ: begin
								bin_q <= cmd.bin[BIN_W-1:0];
								if (cmd.bin <= 7'(MAX_COVER)) state_q <= ST_BRD;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_WR: begin
					pos_q <= pos_nx;
					if (pos_nx == cmd_q.stop) state_q <= ST_DONE;
				end
				ST_ADD: begin
					// read one position per cycle, write it back in the following cycle
					if (pos_q < cmd_q.stop) begin
						rv_s1   <= 1'b1;
						addr_s1 <= pos_q[ADDR_W-1:0];
						pos_q   <= pos_nx;
					end else begin
						rv_s1 <= 1'b0;
						if (!rv_s1) state_q <= ST_DONE;
					end
				end
				ST_HCLR: begin
					if (pos_q == POS_W'(MAX_COVER)) begin
						pos_q   <= '0;
						state_q <= (cmd_q.stop == '0) ? ST_DONE : ST_FRD;
					end else begin
						pos_q <= pos_nx;
					end
				end
				ST_FRD: state_q <= ST_FHIST;
				ST_FHIST: begin
					if (st_rd_q != MASKED) unr_q <= sat_inc(unr_q);
					if (st_rd_q != 8'd0 && st_rd_q <= COV_MAX) begin
						cov_q   <= sat_inc(cov_q);
						bin_q   <= st_rd_q[BIN_W-1:0];
						state_q <= ST_FUPD;
					end else begin
						pos_q   <= pos_nx;
						state_q <= (pos_nx == cmd_q.stop) ? ST_DONE : ST_FRD;
					end
				end
				ST_FUPD: begin
					pos_q   <= pos_nx;
					state_q <= (pos_nx == cmd_q.stop) ? ST_DONE : ST_FRD;
				end
				ST_BRD: begin
					binc_q  <= hs_rd_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q              <= 1'b1;
						out_q.status             <= cmd_q.status;
						out_q.unrestricted_count <= unr_q;
						out_q.depth_sum          <= depth_q;
						out_q.covered_count      <= cov_q;
						out_q.bin_count          <= binc_q;
						state_q                  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/interval_coverage_histogram_top.sv @@
// ----------------------------------------------------------------------------
// interval_coverage_histogram_top
// Per-position coverage store with range masking and a depth histogram.
// ----------------------------------------------------------------------------
// Throughput: one request at a time in the back end. Begin writes every store
// word (one store word per cycle), allow/gap write their range, add is a
// pipelined read-modify-write over the interval, finish clears the histogram
// then scans each position, read bin reads one histogram entry (skipped above
// max cover). The single store port paces these walks; up to two queued requests
// wait in front. Reset clears control, totals and queue, then a pass zeroes the
// histogram before the first request is taken; the store is undefined until begin.
// ----------------------------------------------------------------------------
module interval_coverage_histogram_top import icov_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// request channel
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_item,
	// result channel
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_item,
	// config write port
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [POS_W-1:0] cfg_data
);

	logic [POS_W-1:0] seq_length_q;
	logic             restrict_q;
	logic             cmd_valid, cmd_ready;
	cmd_t             cmd;

	// config registers, to be written only while idle; the block itself has no check for this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_length_q <= POS_ALL;
			restrict_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LENGTH:   seq_length_q <= cfg_data;
				CFG_RESTRICT: restrict_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front: range check and decode into a two-deep queue
	icov_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.seq_length (seq_length_q),
		.restrict_en(restrict_q),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd)
	);

	// back: store walks, finish scan, histogram, result register
	icov_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
